// File: sv/fbs_pkg.sv
// Shared types, constants and byte transforms for the frame byte scrambler.
`timescale 1ns / 1ps

package fbs_pkg;

    localparam int unsigned FRAME_LIMIT = 140;

    localparam logic [7:0] TERM_BYTE = 8'h0d;
    localparam logic [7:0] END_MARK  = 8'hcc;
    localparam logic [3:0] NIB_MASK  = 4'hf;
    localparam int unsigned KEY_ENTRIES = 16;

    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_ENCRYPT = 2'd1;
    localparam logic [1:0] MODE_DECRYPT = 2'd2;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_KEY_HIGH = 2'd2;

    localparam logic [7:0] COUNT_MAX    = 8'hff;
    localparam logic [7:0] LIMIT_BYTE   = 8'(FRAME_LIMIT);

    typedef logic [8*KEY_ENTRIES-1:0] key_tbl_t;

    // up to two result items produced by one input item
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic       l0;
        logic [7:0] b1;
        logic       l1;
    } fbs_res_t;

    function automatic logic [7:0] key_at(input key_tbl_t tbl, input logic [3:0] idx);
        return tbl[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] seed_index(input logic [7:0] seed);
        return (seed[7:4] + seed[3:0]) & NIB_MASK;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [7:0] x, input logic [7:0] k);
        logic [7:0] v;
        v = x ^ k;
        v = {v[3:0], v[7:4]};
        v = {v[5:0], v[7:6]};
        return v ^ k;
    endfunction

    function automatic logic [7:0] dec_byte(input logic [7:0] x, input logic [7:0] k);
        logic [7:0] v;
        v = x ^ k;
        v = {v[1:0], v[7:2]};
        v = {v[3:0], v[7:4]};
        return v ^ k;
    endfunction

endpackage

// File: sv/fbs_ifs.sv
// Valid/ready channel interfaces: input items, result items, register writes.
`timescale 1ns / 1ps

interface fbs_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] data_byte;
    logic       last_in;

    modport source (output valid, output start_req, output data_byte, output last_in,
                    input ready);
    modport sink   (input valid, input start_req, input data_byte, input last_in,
                    output ready);
endinterface

interface fbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

interface fbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/fbs_core.sv
// Frame state and per-item scramble/descramble logic.
`timescale 1ns / 1ps

module fbs_core
    import fbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       start_req,
    input  logic [7:0] data_byte,
    input  logic       last_in,
    input  logic [1:0] mode,
    input  key_tbl_t   key_tbl,
    output fbs_res_t   res
);

    logic [3:0] key_index_reg, key_index_next;
    logic [7:0] check_reg, check_next;
    logic [7:0] count_reg, count_next;
    logic       in_frame_reg, in_frame_next;

    logic [3:0] idx_eff;
    logic [7:0] chk_eff;
    logic [7:0] cnt_eff;
    logic [7:0] cnt_bump;
    logic [7:0] k;
    logic [7:0] enc;
    logic [7:0] dec;
    logic [7:0] enc_chk;

    always_comb
    begin
        // a start item resets the frame state before its byte is looked at
        idx_eff  = start_req ? seed_index(data_byte) : key_index_reg;
        chk_eff  = start_req ? 8'h00 : check_reg;
        cnt_eff  = start_req ? 8'h00 : count_reg;
        cnt_bump = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + 8'd1;
        k        = key_at(key_tbl, idx_eff);
        enc      = enc_byte(data_byte, k);
        dec      = dec_byte(data_byte, k);
        enc_chk  = chk_eff ^ enc;
    end

    always_comb
    begin
        key_index_next = key_index_reg;
        check_next     = check_reg;
        count_next     = count_reg;
        in_frame_next  = in_frame_reg;
        res            = '0;

        if (accept && (start_req || in_frame_reg))
        begin
            case (mode)
                MODE_PLAIN:
                begin
                    key_index_next = idx_eff;
                    check_next     = chk_eff;
                    count_next     = cnt_bump;
                    res.cnt        = 2'd1;
                    res.b0         = data_byte;
                    if (data_byte == TERM_BYTE || cnt_bump >= LIMIT_BYTE)
                    begin
                        res.l0        = 1'b1;
                        in_frame_next = 1'b0;
                    end
                    else
                    begin
                        in_frame_next = 1'b1;
                    end
                end
                MODE_ENCRYPT:
                begin
                    if (start_req)
                    begin
                        in_frame_next  = 1'b1;
                        key_index_next = idx_eff;
                        check_next     = data_byte;
                        count_next     = 8'd1;
                        res.cnt        = 2'd1;
                        res.b0         = data_byte;
                    end
                    else if (data_byte == TERM_BYTE)
                    begin
                        res.cnt       = 2'd1;
                        res.b0        = check_reg;
                        res.l0        = 1'b1;
                        in_frame_next = 1'b0;
                    end
                    else
                    begin
                        key_index_next = idx_eff + 4'd1;
                        check_next     = enc_chk;
                        count_next     = cnt_bump;
                        res.cnt        = 2'd1;
                        res.b0         = enc;
                        if (cnt_bump >= LIMIT_BYTE)
                        begin
                            // limit reached: checksum follows as a second item
                            res.cnt       = 2'd2;
                            res.b1        = enc_chk;
                            res.l1        = 1'b1;
                            in_frame_next = 1'b0;
                        end
                    end
                end
                MODE_DECRYPT:
                begin
                    if (start_req)
                    begin
                        in_frame_next  = 1'b1;
                        key_index_next = idx_eff;
                        check_next     = 8'h00;
                        count_next     = 8'h00;
                    end
                    else if (last_in)
                    begin
                        res.cnt       = 2'd1;
                        res.b0        = END_MARK;
                        res.l0        = 1'b1;
                        in_frame_next = 1'b0;
                    end
                    else
                    begin
                        key_index_next = idx_eff + 4'd1;
                        res.cnt        = 2'd1;
                        res.b0         = dec;
                    end
                end
                default:
                begin
                    // unused mode: item dropped, state kept
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_index_reg <= '0;
            check_reg     <= '0;
            count_reg     <= '0;
            in_frame_reg  <= 1'b0;
        end
        else
        begin
            key_index_reg <= key_index_next;
            check_reg     <= check_next;
            count_reg     <= count_next;
            in_frame_reg  <= in_frame_next;
        end
    end

endmodule

// File: sv/fbs_outq.sv
// Four-entry result queue: takes up to two items per cycle, hands out one per cycle while dout.ready is high.
`timescale 1ns / 1ps

module fbs_outq
    import fbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fbs_res_t res,
    output logic     room,
    fbs_out_if.source dout
);

    localparam int unsigned DEPTH = 4;

    logic [7:0] byte_reg [DEPTH];
    logic       last_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] wr_ptr_b;

    assign room       = (count_reg <= 3'd2);
    assign dout.valid = (count_reg != 3'd0);
    assign dout.out_byte = byte_reg[rd_ptr_reg];
    assign dout.last  = last_reg[rd_ptr_reg];
    assign pop        = dout.valid && dout.ready;
    assign wr_ptr_b   = wr_ptr_reg + 2'd1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + res.cnt;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {1'b0, res.cnt} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (res.cnt != 2'd0)
        begin
            byte_reg[wr_ptr_reg] <= res.b0;
            last_reg[wr_ptr_reg] <= res.l0;
        end
        if (res.cnt == 2'd2)
        begin
            byte_reg[wr_ptr_b] <= res.b1;
            last_reg[wr_ptr_b] <= res.l1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/frame_byte_scrambler_top.sv
// Top level of the frame byte scrambler: configuration registers, core, result queue.
`timescale 1ns / 1ps

// Frame byte scrambler. Takes one input item per clock while din.ready is high and
// places the result items it yields (none, one or two) in a four-entry queue;
// results are registered in the queue and leave at dout in order. din.ready drops
// only while the queue holds three or more items, so with dout.ready held high the
// block sustains one item per cycle (an encrypt item that hits the frame limit adds
// a checksum item behind its encrypted byte). Register writes are always taken
// (cfg.ready is tied high) and must happen only while the block is idle. Index 0 is
// mode, 1 is key entries 0..7, 2 is key entries 8..15; index 3 is ignored.

module frame_byte_scrambler_top
    import fbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fbs_cfg_if.sink   cfg,
    fbs_in_if.sink    din,
    fbs_out_if.source dout
);

    logic [1:0]  mode_reg;
    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic        room;
    logic        accept;
    fbs_res_t    res;

    assign cfg.ready = 1'b1;
    assign din.ready = room;
    assign accept    = din.valid && room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_PLAIN;
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MODE:     mode_reg     <= cfg.data[1:0];
                REG_KEY_LOW:  key_low_reg  <= cfg.data;
                REG_KEY_HIGH: key_high_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    fbs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start_req (din.start_req),
        .data_byte (din.data_byte),
        .last_in   (din.last_in),
        .mode      (mode_reg),
        .key_tbl   ({key_high_reg, key_low_reg}),
        .res       (res)
    );

    fbs_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .res   (res),
        .room  (room),
        .dout  (dout)
    );

endmodule

// File: sv/fbs_checker.sv
// Port-level checks for the frame byte scrambler, bound to the top level.
`timescale 1ns / 1ps

module fbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("result changed while stalled");

    // no result appears from nowhere
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) && !out_valid |=> !out_valid)
        else $error("result without accepted item");

    // empty queue always has room
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty queue");

endmodule

bind frame_byte_scrambler_top fbs_checker u_fbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_byte  (dout.out_byte),
    .out_last  (dout.last)
);
